// ===== hw/rtl/smau_pkg.sv =====
// Shared types and codes for the square matrix arithmetic unit.
package smau_pkg;

    localparam int unsigned MAX_ORDER = 8;
    localparam int unsigned ORDER_W  = 4;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STAT_W   = 2;
    localparam logic [ORDER_W-1:0] ORDER_RST = 4'd3;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_PROD  = 3'd0,
        K_SUM   = 3'd1,
        K_DIFF  = 3'd2,
        K_REM   = 3'd3,
        K_QUOT  = 3'd4,
        K_TR_A  = 3'd5,
        K_TR_B  = 3'd6,
        K_NONE  = 3'd7
    } t_kind;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV0  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              load_a;
        logic              load_b;
        logic              bad_idx;
        t_kind             kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ORDER_W-1:0] n;
        logic [DATA_W-1:0] value;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WAIT,
        S_EXEC,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_DIV,
        S_DIV_FIX,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/square_matrix_arith_unit_core.sv =====
// Top level of the square matrix arithmetic unit.
// Loads give no result. A query runs alone in the back end: sum,
// difference and transpose are formed in the execute state, a product
// on the single multiply-accumulate loop, and a quotient or remainder
// in the bit-serial divider. A two-entry command queue lets loads and
// the next request be taken while a query is worked on, and the result
// register holds one answer until popped.
module square_matrix_arith_unit_core
    import smau_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_operation,
    input  logic [IDX_W-1:0]    i_row,
    input  logic [IDX_W-1:0]    i_col,
    input  logic [DATA_W-1:0]   i_load_value,
    input  logic [2:0]          i_result_kind,
    output logic                empty,
    input  logic                pop,
    output logic [DATA_W-1:0]   o_result_value,
    output logic [STAT_W-1:0]   o_status,
    input  logic                i_cfg_we,
    input  logic [ORDER_W-1:0]  i_cfg_wdata
);

    logic [ORDER_W-1:0] r_order;
    logic               w_valid;
    logic               w_take;
    t_cmd               w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RST;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    smau_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .full          (full),
        .i_operation   (i_operation),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_load_value  (i_load_value),
        .i_result_kind (i_result_kind),
        .i_order       (r_order),
        .i_max_order   (ORDER_W'(MAX_ORDER)),
        .i_cmd_take    (w_take),
        .o_cmd_valid   (w_valid),
        .o_cmd         (w_cmd)
    );

    smau_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_valid),
        .i_cmd          (w_cmd),
        .o_cmd_take     (w_take),
        .pop            (pop),
        .empty          (empty),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

// ===== hw/rtl/smau_front.sv =====
// Front end: accept requests, clamp order, classify and queue commands.
module smau_front
    import smau_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               full,
    input  logic [1:0]         i_operation,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [DATA_W-1:0]  i_load_value,
    input  logic [2:0]         i_result_kind,
    input  logic [ORDER_W-1:0] i_order,
    input  logic [ORDER_W-1:0] i_max_order,
    input  logic               i_cmd_take,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd
);

    t_cmd             r_q [2];
    logic [1:0]       r_cnt;
    logic             r_wp;
    logic             r_rp;
    t_cmd             n_cmd;
    logic [ORDER_W-1:0] n_eff;
    logic             w_push;
    logic             w_keep;

    always_comb begin
        if (i_order == '0) begin
            n_eff = ORDER_W'(1);
        end else if (i_order > i_max_order) begin
            n_eff = i_max_order;
        end else begin
            n_eff = i_order;
        end
        n_cmd.row     = i_row;
        n_cmd.col     = i_col;
        n_cmd.n       = n_eff;
        n_cmd.value   = i_load_value;
        n_cmd.kind    = t_kind'(i_result_kind);
        n_cmd.bad_idx = ({1'b0, i_row} >= n_eff) || ({1'b0, i_col} >= n_eff);
        n_cmd.load_a  = (t_op'(i_operation) == OP_LOAD_A);
        n_cmd.load_b  = (t_op'(i_operation) == OP_LOAD_B);
        w_keep = (t_op'(i_operation) == OP_QUERY)
            || ((n_cmd.load_a || n_cmd.load_b) && !n_cmd.bad_idx);
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = i_push && !full && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take && o_cmd_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_take && o_cmd_valid);
        end
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/smau_div.sv =====
// Iterative signed divider, one quotient bit per cycle.
module smau_div
    import smau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);

    logic              r_busy;
    logic [5:0]        r_cnt;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W:0]   r_r;
    logic [DATA_W-1:0] r_d;
    logic              r_nq;
    logic              r_nr;
    logic              r_done;
    logic [DATA_W:0]   n_sh;
    logic [DATA_W:0]   n_sub;

    always_comb begin
        n_sh  = {r_r[DATA_W-1:0], r_q[DATA_W-1]};
        n_sub = n_sh - {1'b0, r_d};
    end

    assign o_done = r_done;
    assign o_quot = r_nq ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_nr ? (~r_r[DATA_W-1:0] + 1'b1) : r_r[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q  <= i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
            r_d  <= i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;
            r_r  <= '0;
            r_nq <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_nr <= i_num[DATA_W-1];
        end else if (r_busy) begin
            if (!n_sub[DATA_W]) begin
                r_r <= n_sub;
                r_q <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_r <= n_sh;
                r_q <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/smau_back.sv =====
// Back end: matrix stores, query sequencer with multiply-accumulate loop and divider, and one-entry result register.
module smau_back
    import smau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_take,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] o_result_value,
    output logic [STAT_W-1:0] o_status
);

    localparam int unsigned CELLS = MAX_ORDER * MAX_ORDER;
    localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [DATA_W-1:0] r_ma [CELLS];
    logic [DATA_W-1:0] r_mb [CELLS];
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [AW-1:0]     n_aa;
    logic [AW-1:0]     n_ab;
    logic [AW-1:0]     n_wa;

    t_state            r_st;
    t_state            n_st;
    t_cmd              r_cmd;
    logic [ORDER_W-1:0] r_k;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_res;
    logic [STAT_W-1:0] r_stat;
    logic              r_full;
    logic              w_take;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic [DATA_W-1:0] w_rem;

    function automatic logic [AW-1:0] addr(input logic [ORDER_W-1:0] r,
                                            input logic [ORDER_W-1:0] c);
        logic [31:0] t;
        t = 32'(r) * 32'(MAX_ORDER) + 32'(c);
        return t[AW-1:0];
    endfunction

    smau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a),
        .i_den   (r_b),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    assign w_take     = (r_st == S_IDLE) && i_cmd_valid;
    assign o_cmd_take = w_take;
    assign n_wa       = addr({1'b0, i_cmd.row}, {1'b0, i_cmd.col});
    assign w_div_start = (r_st == S_EXEC) && (r_cmd.kind == K_REM || r_cmd.kind == K_QUOT)
        && (r_b != '0);

    always_comb begin
        n_aa = addr({1'b0, r_cmd.row}, {1'b0, r_cmd.col});
        n_ab = n_aa;
        unique case (r_st)
            S_RD, S_WAIT: begin
                if (r_cmd.kind == K_TR_A || r_cmd.kind == K_TR_B) begin
                    n_aa = addr({1'b0, r_cmd.col}, {1'b0, r_cmd.row});
                    n_ab = n_aa;
                end
            end
            S_MAC_RD: begin
                n_aa = addr({1'b0, r_cmd.row}, r_k);
                n_ab = addr(r_k, {1'b0, r_cmd.col});
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (i_cmd_valid && !i_cmd.load_a && !i_cmd.load_b) begin
                    n_st = S_RD;
                end
            end
            S_RD: begin
                if (r_cmd.bad_idx || r_cmd.kind == K_NONE) begin
                    n_st = S_OUT;
                end else if (r_cmd.kind == K_PROD) begin
                    n_st = S_MAC_RD;
                end else begin
                    n_st = S_WAIT;
                end
            end
            S_WAIT: n_st = S_EXEC;
            S_EXEC: n_st = w_div_start ? S_DIV : S_OUT;
            S_MAC_RD: n_st = S_MAC_MUL;
            S_MAC_MUL: n_st = S_MAC_ACC;
            S_MAC_ACC: n_st = (r_k == r_cmd.n) ? S_OUT : S_MAC_RD;
            S_DIV: n_st = w_div_done ? S_DIV_FIX : S_DIV;
            S_DIV_FIX: n_st = S_OUT;
            S_OUT: n_st = r_full ? S_OUT : S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_cmd.load_a) begin
            r_ma[n_wa] <= i_cmd.value;
        end
        if (w_take && i_cmd.load_b) begin
            r_mb[n_wa] <= i_cmd.value;
        end
        r_a <= r_ma[n_aa];
        r_b <= r_mb[n_ab];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_full <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT && !r_full) begin
                r_full <= 1'b1;
            end else if (pop) begin
                r_full <= 1'b0;
            end
        end
        if (w_take) begin
            r_cmd <= i_cmd;
        end
        unique case (r_st)
            S_RD: begin
                r_k    <= '0;
                r_acc  <= '0;
                r_res  <= '0;
                r_stat <= r_cmd.bad_idx ? ST_RANGE : ST_OK;
            end
            S_MAC_MUL: begin
                r_prod <= 32'(r_a * r_b);
                r_k    <= r_k + 1'b1;
            end
            S_MAC_ACC: begin
                r_acc <= r_acc + r_prod;
                r_res <= r_acc + r_prod;
            end
            S_EXEC: begin
                unique case (r_cmd.kind)
                    K_SUM:  r_res <= r_a + r_b;
                    K_DIFF: r_res <= r_a - r_b;
                    K_TR_A: r_res <= r_a;
                    K_TR_B: r_res <= r_b;
                    K_REM, K_QUOT: begin
                        if (r_b == '0) begin
                            r_stat <= ST_DIV0;
                        end
                    end
                    default: r_res <= '0;
                endcase
            end
            S_DIV_FIX: r_res <= (r_cmd.kind == K_REM) ? w_rem : w_quot;
            default: begin
            end
        endcase
        if (r_st == S_OUT && !r_full) begin
            o_result_value <= r_res;
            o_status       <= r_stat;
        end
    end

    assign empty = !r_full;

endmodule

// ===== sim/square_matrix_arith_unit_core_tb.sv =====
// Self-checking testbench for the square matrix arithmetic unit core.
`timescale 1ns / 1ps

module square_matrix_arith_unit_core_tb;
    import smau_pkg::*;

    localparam int unsigned DIM = MAX_ORDER;

    typedef struct {
        t_op               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        t_kind             kind;
        bit                typed;
        logic [DATA_W-1:0] want_value;
        logic [STAT_W-1:0] want_status;
    } t_request;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_operation;
    logic [IDX_W-1:0]   i_row;
    logic [IDX_W-1:0]   i_col;
    logic [DATA_W-1:0]  i_load_value;
    logic [2:0]         i_result_kind;
    logic               empty;
    logic               pop;
    logic [DATA_W-1:0]  o_result_value;
    logic [STAT_W-1:0]  o_status;
    logic               i_cfg_we;
    logic [ORDER_W-1:0] i_cfg_wdata;

    logic [DATA_W-1:0]  mat_a [DIM*DIM];
    logic [DATA_W-1:0]  mat_b [DIM*DIM];
    logic [ORDER_W-1:0] order_reg;
    t_answer            pending_answers[$];
    t_request           directed_rows[$];
    int                 errors;
    int                 answers_seen;
    bit                 send_burst;
    bit                 take_burst;

    square_matrix_arith_unit_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_load_value   (i_load_value),
        .i_result_kind  (i_result_kind),
        .empty          (empty),
        .pop            (pop),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned eff_order();
        if (order_reg == 0) return 1;
        if (order_reg > DIM) return DIM;
        return 32'(order_reg);
    endfunction

    // Update the matrices and return whether the request yields an answer.
    function automatic bit compute_matrix_answer(input t_request r, output t_answer ans);
        int unsigned n;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [DATA_W-1:0] acc;
        n = eff_order();
        ans.value = '0;
        ans.status = ST_OK;
        if (r.op == OP_LOAD_A || r.op == OP_LOAD_B) begin
            if (r.row < n && r.col < n) begin
                if (r.op == OP_LOAD_A) mat_a[r.row*DIM + r.col] = r.value;
                else mat_b[r.row*DIM + r.col] = r.value;
            end
            return 0;
        end
        if (r.op != OP_QUERY) return 0;
        if (r.row >= n || r.col >= n) begin
            ans.status = ST_RANGE;
            return 1;
        end
        a = mat_a[r.row*DIM + r.col];
        b = mat_b[r.row*DIM + r.col];
        case (r.kind)
            K_PROD: begin
                acc = '0;
                for (int k = 0; k < n; k++)
                    acc = acc + mat_a[r.row*DIM + k] * mat_b[k*DIM + r.col];
                ans.value = acc;
            end
            K_SUM:  ans.value = a + b;
            K_DIFF: ans.value = a - b;
            K_REM, K_QUOT: begin
                if (b == 0) ans.status = ST_DIV0;
                else if (a == 32'sh8000_0000 && b == -32'sd1)
                    ans.value = (r.kind == K_QUOT) ? 32'h8000_0000 : '0;
                else ans.value = (r.kind == K_QUOT) ? a / b : a % b;
            end
            K_TR_A: ans.value = mat_a[r.col*DIM + r.row];
            K_TR_B: ans.value = mat_b[r.col*DIM + r.row];
            default: ans.value = '0;
        endcase
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        errors++;
        $display("mismatch %0s: want %h got %h at %0t", what, want, got, $realtime);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return DATA_W'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request rand_request();
        t_request r;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        r.op = (pick < 4) ? OP_LOAD_A : (pick < 8) ? OP_LOAD_B :
               (pick < 19) ? OP_QUERY : OP_NONE;
        r.row = IDX_W'($urandom_range(0, 7));
        r.col = IDX_W'($urandom_range(0, 7));
        r.value = rand_value();
        r.kind = t_kind'($urandom_range(0, 7));
        r.typed = 0;
        return r;
    endfunction

    task automatic send_request(input t_request r);
        int unsigned gap;
        bit ok;
        t_answer ans;
        if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_operation <= r.op;
        i_row <= r.row;
        i_col <= r.col;
        i_load_value <= r.value;
        i_result_kind <= r.kind;
        do begin
            @(negedge i_clk);
            ok = !full;
            @(posedge i_clk);
        end while (!ok);
        if (compute_matrix_answer(r, ans)) begin
            if (r.typed) begin
                ans.value = r.want_value;
                ans.status = r.want_status;
            end
            pending_answers.push_back(ans);
        end
    endtask

    task automatic add_row(input t_op op, input int row, input int col,
                           input logic [DATA_W-1:0] value, input t_kind kind, input bit typed,
                           input logic [DATA_W-1:0] want_value,
                           input logic [STAT_W-1:0] want_status);
        t_request r;
        r.op = op;
        r.row = IDX_W'(row);
        r.col = IDX_W'(col);
        r.value = value;
        r.kind = kind;
        r.typed = typed;
        r.want_value = want_value;
        r.want_status = want_status;
        directed_rows.push_back(r);
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        order_reg = value;
    endtask

    task automatic fill_matrices();
        t_request r;
        int unsigned n;
        n = eff_order();
        for (int m = 0; m < 2; m++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    r = rand_request();
                    r.op = (m == 0) ? OP_LOAD_A : OP_LOAD_B;
                    r.row = IDX_W'(i);
                    r.col = IDX_W'(j);
                    send_request(r);
                end
    endtask

    // Receiver: pop answers with random stalls and one long hold-off.
    initial begin
        int unsigned gap;
        bit got;
        t_answer seen;
        t_answer want;
        pop = 1'b0;
        take_burst = 0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
            gap = take_burst ? 0 : $urandom_range(0, 7);
            if (answers_seen == 40) gap = 400;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge i_clk);
                got = !empty;
                seen.value = o_result_value;
                seen.status = o_status;
                @(posedge i_clk);
            end while (!got);
            answers_seen++;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected answer", '0, seen.value);
            end else begin
                want = pending_answers.pop_front();
                if (seen.value != want.value)
                    report_mismatch("value", want.value, seen.value);
                if (seen.status != want.status)
                    report_mismatch("status", DATA_W'(want.status), DATA_W'(seen.status));
            end
        end
    end

    initial begin
        logic [ORDER_W-1:0] orders [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2};
        int counted;
        t_request r;
        errors = 0;
        answers_seen = 0;
        send_burst = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_operation = OP_NONE;
        i_row = '0;
        i_col = '0;
        i_load_value = '0;
        i_result_kind = K_NONE;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        for (int i = 0; i < DIM*DIM; i++) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        order_reg = ORDER_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(OP_QUERY,  3, 0, '0, K_SUM,  1, '0, ST_RANGE);
        add_row(OP_QUERY,  0, 7, '0, K_PROD, 1, '0, ST_RANGE);
        add_row(OP_QUERY,  7, 7, '0, K_QUOT, 1, '0, ST_RANGE);
        add_row(OP_NONE,   1, 1, 32'h1234_5678, K_SUM, 0, '0, ST_OK);
        add_row(OP_LOAD_A, 5, 5, 32'd123, K_SUM, 0, '0, ST_OK);
        add_row(OP_LOAD_B, 0, 3, 32'd123, K_SUM, 0, '0, ST_OK);
        add_row(OP_LOAD_A, 0, 0, 32'h8000_0000, K_SUM, 0, '0, ST_OK);
        add_row(OP_LOAD_B, 0, 0, 32'hffff_ffff, K_SUM, 0, '0, ST_OK);
        add_row(OP_QUERY,  0, 0, '0, K_QUOT, 1, 32'h8000_0000, ST_OK);
        add_row(OP_QUERY,  0, 0, '0, K_REM,  1, '0, ST_OK);
        add_row(OP_LOAD_B, 1, 1, '0, K_SUM, 0, '0, ST_OK);
        add_row(OP_QUERY,  1, 1, '0, K_REM,  1, '0, ST_DIV0);
        add_row(OP_QUERY,  1, 1, '0, K_QUOT, 1, '0, ST_DIV0);
        add_row(OP_QUERY,  1, 1, '0, K_NONE, 1, '0, ST_OK);
        add_row(OP_LOAD_A, 2, 2, 32'h7fff_ffff, K_SUM, 0, '0, ST_OK);
        add_row(OP_LOAD_B, 2, 2, 32'd1, K_SUM, 0, '0, ST_OK);
        add_row(OP_QUERY,  2, 2, '0, K_SUM,  1, 32'h8000_0000, ST_OK);
        add_row(OP_QUERY,  2, 1, '0, K_DIFF, 0, '0, ST_OK);
        add_row(OP_QUERY,  1, 2, '0, K_PROD, 0, '0, ST_OK);
        add_row(OP_QUERY,  2, 2, '0, K_PROD, 0, '0, ST_OK);
        add_row(OP_QUERY,  0, 2, '0, K_TR_A, 0, '0, ST_OK);
        add_row(OP_QUERY,  2, 0, '0, K_TR_B, 0, '0, ST_OK);

        for (int p = 0; p <= 6; p++) begin
            if (p > 0) begin
                drain_and_settle();
                write_order(orders[p-1]);
            end
            fill_matrices();
            if (p == 0)
                foreach (directed_rows[i]) send_request(directed_rows[i]);
            counted = 0;
            while (counted < 110) begin
                r = rand_request();
                if (r.op != OP_NONE &&
                    !(r.op != OP_QUERY && (r.row >= eff_order() || r.col >= eff_order())))
                    counted++;
                send_request(r);
            end
        end
        drain_and_settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/smau_pkg.sv
hw/rtl/smau_front.sv
hw/rtl/smau_div.sv
hw/rtl/smau_back.sv
hw/rtl/square_matrix_arith_unit_core.sv
sim/square_matrix_arith_unit_core_tb.sv
